// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands for the lifecycle gate.
// Each check is sampled on the rising edge and is held off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define ULG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ulg assertion failed");

// Condition that must never be seen at a sampled edge.
`define ULG_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ulg forbidden condition seen");

`endif

// ===== rtl/core/ulg_pkg.sv =====
package ulg_pkg;

    // item kinds
    localparam logic [2:0] MODE_EVENT    = 3'd0;
    localparam logic [2:0] MODE_CONFIG   = 3'd1;
    localparam logic [2:0] MODE_STORAGE  = 3'd2;
    localparam logic [2:0] MODE_RECOVERY = 3'd3;
    localparam logic [2:0] MODE_FAULT    = 3'd4;

    // bus event codes
    localparam logic [2:0] EV_ATTACH    = 3'd0;
    localparam logic [2:0] EV_BUS_RESET = 3'd1;
    localparam logic [2:0] EV_CDC_OPEN  = 3'd2;
    localparam logic [2:0] EV_SUSPEND   = 3'd3;
    localparam logic [2:0] EV_RESUME    = 3'd4;
    localparam logic [2:0] EV_DETACH    = 3'd5;

    // recovery origins
    localparam logic [2:0] ORG_REMOTE    = 3'd0;
    localparam logic [2:0] ORG_LAST_GOOD = 3'd3;

    // lifecycle states
    localparam logic [2:0] ST_DETACHED    = 3'd0;
    localparam logic [2:0] ST_ATTACHED    = 3'd1;
    localparam logic [2:0] ST_ENUMERATING = 3'd2;
    localparam logic [2:0] ST_CONFIGURED  = 3'd3;
    localparam logic [2:0] ST_READY       = 3'd4;
    localparam logic [2:0] ST_SUSPENDED   = 3'd5;
    localparam logic [2:0] ST_RECOVERY    = 3'd6;
    localparam logic [2:0] ST_FAULT       = 3'd7;

    // status codes
    localparam logic [3:0] RS_OK         = 4'd0;
    localparam logic [3:0] RS_BAD_ARG    = 4'd1;
    localparam logic [3:0] RS_BAD_TRANS  = 4'd2;
    localparam logic [3:0] RS_BAD_CONFIG = 4'd3;
    localparam logic [3:0] RS_NOT_READY  = 4'd4;
    localparam logic [3:0] RS_CURRENT    = 4'd5;
    localparam logic [3:0] RS_POWER      = 4'd6;
    localparam logic [3:0] RS_REMOTE     = 4'd7;
    localparam logic [3:0] RS_STORAGE    = 4'd9;
    localparam logic [3:0] RS_FAULT      = 4'd10;

    localparam logic [7:0] MAX_CONFIG_RESET = 8'd1;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] event_code;
        logic [7:0] config_number;
        logic       storage_mutating;
        logic       current_available;
        logic       rail_safe;
        logic [3:0] storage_verdict;
        logic [2:0] recovery_origin;
    } ulg_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  state_now;
        logic        config_active;
        logic        serial_open;
        logic [3:0]  error_latched;
        logic        forward_storage;
        logic [31:0] event_count;
        logic [31:0] bad_transition_count;
        logic [31:0] storage_rejected_count;
        logic [31:0] storage_forwarded_count;
        logic [31:0] remote_reject_count;
        logic [3:0]  last_storage_code;
    } ulg_out_t;

    // current context seen by the decision logic
    typedef struct packed {
        logic [2:0] state;
        logic       cfg_flag;
        logic       ser_flag;
        logic [7:0] max_cfg;
    } ulg_ctx_t;

    // decision handed to the state holder
    typedef struct packed {
        logic [3:0] status;
        logic [2:0] state_next;
        logic       cfg_next;
        logic       ser_next;
        logic       fwd;
        logic       inc_event;
        logic       inc_bad;
        logic       inc_rej;
        logic       inc_fwd;
        logic       inc_remote;
        logic       load_code;
        logic [3:0] code;
    } ulg_upd_t;

endpackage

// ===== rtl/core/ulg_decide.sv =====
module ulg_decide
    import ulg_pkg::*;
(
    input  ulg_in_t  item,
    input  ulg_ctx_t ctx,
    output ulg_upd_t upd
);

    logic fault;

    assign fault = (ctx.state == ST_FAULT);

    always_comb
    begin
        upd            = '0;
        upd.state_next = ctx.state;
        upd.cfg_next   = ctx.cfg_flag;
        upd.ser_next   = ctx.ser_flag;
        upd.code       = item.storage_verdict;
        upd.status     = RS_BAD_ARG;

        case (item.mode)
            MODE_EVENT:
            begin
                if (fault)
                begin
                    upd.status = RS_FAULT;
                end
                else
                begin
                    upd.inc_event = 1'b1;
                    upd.status    = RS_BAD_TRANS;
                    case (item.event_code)
                        EV_ATTACH:
                        begin
                            if (ctx.state == ST_DETACHED)
                            begin
                                upd.cfg_next   = 1'b0;
                                upd.ser_next   = 1'b0;
                                upd.state_next = ST_ATTACHED;
                                upd.status     = RS_OK;
                            end
                        end
                        EV_BUS_RESET:
                        begin
                            if (!(ctx.state inside {ST_DETACHED, ST_RECOVERY}))
                            begin
                                upd.cfg_next   = 1'b0;
                                upd.ser_next   = 1'b0;
                                upd.state_next = ST_ENUMERATING;
                                upd.status     = RS_OK;
                            end
                        end
                        EV_CDC_OPEN:
                        begin
                            if (ctx.state == ST_CONFIGURED && ctx.cfg_flag)
                            begin
                                upd.ser_next   = 1'b1;
                                upd.state_next = ST_READY;
                                upd.status     = RS_OK;
                            end
                        end
                        EV_SUSPEND:
                        begin
                            if (ctx.state inside {ST_CONFIGURED, ST_READY})
                            begin
                                upd.ser_next   = 1'b0;
                                upd.state_next = ST_SUSPENDED;
                                upd.status     = RS_OK;
                            end
                        end
                        EV_RESUME:
                        begin
                            if (ctx.state == ST_SUSPENDED)
                            begin
                                upd.ser_next   = 1'b0;
                                upd.state_next = ST_CONFIGURED;
                                upd.status     = RS_OK;
                            end
                        end
                        EV_DETACH:
                        begin
                            if (ctx.state != ST_DETACHED)
                            begin
                                upd.cfg_next   = 1'b0;
                                upd.ser_next   = 1'b0;
                                upd.state_next = ST_DETACHED;
                                upd.status     = RS_OK;
                            end
                        end
                        default:
                        begin
                            upd.status = RS_BAD_ARG;
                        end
                    endcase
                end
            end
            MODE_CONFIG:
            begin
                if (fault)
                begin
                    upd.status = RS_FAULT;
                end
                else if (item.config_number > ctx.max_cfg)
                begin
                    upd.status = RS_BAD_CONFIG;
                end
                else if (!(ctx.state inside {ST_ENUMERATING, ST_CONFIGURED, ST_READY}))
                begin
                    upd.status = RS_BAD_TRANS;
                end
                else
                begin
                    upd.inc_event = 1'b1;
                    upd.ser_next  = 1'b0;
                    upd.status    = RS_OK;
                    if (item.config_number == '0)
                    begin
                        upd.cfg_next   = 1'b0;
                        upd.state_next = ST_ENUMERATING;
                    end
                    else
                    begin
                        upd.cfg_next   = 1'b1;
                        upd.state_next = ST_CONFIGURED;
                    end
                end
            end
            MODE_STORAGE:
            begin
                upd.inc_rej = 1'b1;
                if (fault)
                begin
                    upd.status = RS_FAULT;
                end
                else if (ctx.state != ST_READY || !ctx.cfg_flag || !ctx.ser_flag)
                begin
                    upd.status = RS_NOT_READY;
                end
                else if (item.storage_mutating && !item.current_available)
                begin
                    upd.status = RS_CURRENT;
                end
                else if (item.storage_mutating && !item.rail_safe)
                begin
                    upd.status = RS_POWER;
                end
                else
                begin
                    upd.load_code = 1'b1;
                    if (item.storage_verdict != '0)
                    begin
                        upd.status = RS_STORAGE;
                    end
                    else
                    begin
                        upd.inc_rej = 1'b0;
                        upd.inc_fwd = 1'b1;
                        upd.fwd     = 1'b1;
                        upd.status  = RS_OK;
                    end
                end
            end
            MODE_RECOVERY:
            begin
                if (fault)
                begin
                    upd.status = RS_FAULT;
                end
                else if (item.recovery_origin == ORG_REMOTE)
                begin
                    upd.inc_remote = 1'b1;
                    upd.status     = RS_REMOTE;
                end
                else if (item.recovery_origin > ORG_LAST_GOOD)
                begin
                    upd.status = RS_BAD_ARG;
                end
                else
                begin
                    upd.cfg_next   = 1'b0;
                    upd.ser_next   = 1'b0;
                    upd.state_next = ST_RECOVERY;
                    upd.inc_event  = 1'b1;
                    upd.status     = RS_OK;
                end
            end
            MODE_FAULT:
            begin
                upd.cfg_next   = 1'b0;
                upd.ser_next   = 1'b0;
                upd.state_next = ST_FAULT;
                upd.status     = RS_FAULT;
            end
            default:
            begin
                upd.status = RS_BAD_ARG;
            end
        endcase

        upd.inc_bad = (upd.status == RS_BAD_TRANS);
    end

endmodule

// ===== rtl/core/ulg_state.sv =====
`include "assert_macros.svh"

module ulg_state
    import ulg_pkg::*;
#(
    parameter int CW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_data,
    input  logic          upd_en,
    input  ulg_upd_t      upd,
    output ulg_ctx_t      ctx,
    output logic [3:0]    err_next,
    output logic [3:0]    code_next,
    output logic [CW-1:0] ev_cnt_next,
    output logic [CW-1:0] bad_cnt_next,
    output logic [CW-1:0] rej_cnt_next,
    output logic [CW-1:0] fwd_cnt_next,
    output logic [CW-1:0] rem_cnt_next
);

    logic [2:0]    state_reg;
    logic          cfg_flag_reg;
    logic          ser_flag_reg;
    logic [7:0]    max_cfg_reg;
    logic [3:0]    err_reg;
    logic [3:0]    code_reg;
    logic [CW-1:0] ev_cnt_reg;
    logic [CW-1:0] bad_cnt_reg;
    logic [CW-1:0] rej_cnt_reg;
    logic [CW-1:0] fwd_cnt_reg;
    logic [CW-1:0] rem_cnt_reg;

    assign ctx.state    = state_reg;
    assign ctx.cfg_flag = cfg_flag_reg;
    assign ctx.ser_flag = ser_flag_reg;
    assign ctx.max_cfg  = max_cfg_reg;

    // error register takes the item's status whenever the item advances
    assign err_next     = upd.status;
    assign code_next    = upd.load_code ? upd.code : code_reg;
    assign ev_cnt_next  = ev_cnt_reg + CW'(upd.inc_event);
    assign bad_cnt_next = bad_cnt_reg + CW'(upd.inc_bad);
    assign rej_cnt_next = rej_cnt_reg + CW'(upd.inc_rej);
    assign fwd_cnt_next = fwd_cnt_reg + CW'(upd.inc_fwd);
    assign rem_cnt_next = rem_cnt_reg + CW'(upd.inc_remote);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cfg_reg <= MAX_CONFIG_RESET;
        end
        else if (cfg_we)
        begin
            max_cfg_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_DETACHED;
            cfg_flag_reg <= 1'b0;
            ser_flag_reg <= 1'b0;
            err_reg      <= RS_OK;
            code_reg     <= RS_OK;
            ev_cnt_reg   <= '0;
            bad_cnt_reg  <= '0;
            rej_cnt_reg  <= '0;
            fwd_cnt_reg  <= '0;
            rem_cnt_reg  <= '0;
        end
        else if (upd_en)
        begin
            state_reg    <= upd.state_next;
            cfg_flag_reg <= upd.cfg_next;
            ser_flag_reg <= upd.ser_next;
            err_reg      <= err_next;
            code_reg     <= code_next;
            ev_cnt_reg   <= ev_cnt_next;
            bad_cnt_reg  <= bad_cnt_next;
            rej_cnt_reg  <= rej_cnt_next;
            fwd_cnt_reg  <= fwd_cnt_next;
            rem_cnt_reg  <= rem_cnt_next;
        end
    end

    // fault lock is sticky until reset
    `ULG_ASSERT(a_fault_sticky, clk, rst_n, (state_reg == ST_FAULT) |=> (state_reg == ST_FAULT))
    // no flags survive in fault lock
    `ULG_NEVER(a_fault_flags, clk, rst_n, (state_reg == ST_FAULT) && (cfg_flag_reg || ser_flag_reg))
    // error register mirrors the last status
    `ULG_ASSERT(a_err_tracks, clk, rst_n, upd_en |=> (err_reg == $past(upd.status)))

endmodule

// ===== rtl/core/usb_device_lifecycle_gate_unit.sv =====
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  ulg_in_t   one lifecycle item
// out       output     out_valid/out_stall ulg_out_t one result per item
// cfg       input      cfg_valid/cfg_ready 8 bit     max_config_value
//
// Path: input register, then result register, whose contents appear on out.
// Throughput: one item per cycle while out_stall does not hold the result
// register; the input register, the decision logic and the result register
// form a single pass with the state loop closed around the decision logic.
// Reset: rst_n clears lifecycle state, flags, counters and both valids;
// max_config_value returns to 1.
// Stalls: out_stall holds the result register; the input register keeps
// taking items until it is full and the result register cannot drain.
`include "assert_macros.svh"

module usb_device_lifecycle_gate_unit
    import ulg_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ulg_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output ulg_out_t   out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    // input register
    logic     in_vld_reg;
    ulg_in_t  in_item_reg;

    // result register
    logic     out_vld_reg;
    ulg_out_t out_item_reg;

    logic     advance;
    logic     in_take;
    ulg_ctx_t ctx;
    ulg_upd_t upd;
    ulg_out_t result;

    logic [3:0]              err_next;
    logic [3:0]              code_next;
    logic [COUNTER_BITS-1:0] ev_cnt_next;
    logic [COUNTER_BITS-1:0] bad_cnt_next;
    logic [COUNTER_BITS-1:0] rej_cnt_next;
    logic [COUNTER_BITS-1:0] fwd_cnt_next;
    logic [COUNTER_BITS-1:0] rem_cnt_next;

    // item moves on when the result register is free or draining
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = !in_vld_reg;

    ulg_decide u_decide
    (
        .item (in_item_reg),
        .ctx  (ctx),
        .upd  (upd)
    );

    ulg_state #(
        .CW (COUNTER_BITS)
    ) u_state
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .upd_en       (advance),
        .upd          (upd),
        .ctx          (ctx),
        .err_next     (err_next),
        .code_next    (code_next),
        .ev_cnt_next  (ev_cnt_next),
        .bad_cnt_next (bad_cnt_next),
        .rej_cnt_next (rej_cnt_next),
        .fwd_cnt_next (fwd_cnt_next),
        .rem_cnt_next (rem_cnt_next)
    );

    // result reflects the state after the transaction; counters fold to 32 bits
    always_comb
    begin
        result.status                  = upd.status;
        result.state_now               = upd.state_next;
        result.config_active           = upd.cfg_next;
        result.serial_open             = upd.ser_next;
        result.error_latched           = err_next;
        result.forward_storage         = upd.fwd;
        result.event_count             = 32'(ev_cnt_next);
        result.bad_transition_count    = 32'(bad_cnt_next);
        result.storage_rejected_count  = 32'(rej_cnt_next);
        result.storage_forwarded_count = 32'(fwd_cnt_next);
        result.remote_reject_count     = 32'(rem_cnt_next);
        result.last_storage_code       = code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

    // a forwarded storage request always reports ok
    `ULG_ASSERT(a_fwd_ok, clk, rst_n, (out_valid && out_data.forward_storage) |-> (out_data.status == RS_OK))
    // input side only pushes back while holding an item
    `ULG_ASSERT(a_stall_full, clk, rst_n, in_stall |-> in_vld_reg)
    // an item that moves on always lands in the result register
    `ULG_ASSERT(a_advance_lands, clk, rst_n, advance |=> out_vld_reg)

endmodule
